@@ hdl/csv_numeric_field_parser_unit_defines.svh @@
// Assertion helpers used by the bound property checker.
`ifndef CSV_NUMERIC_FIELD_PARSER_UNIT_DEFINES_SVH
`define CSV_NUMERIC_FIELD_PARSER_UNIT_DEFINES_SVH

// Checked only outside reset.
`define CSVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define CSVP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/csvp_pkg.sv @@
package csvp_pkg;

  // register indexes
  localparam logic [2:0] REG_SKIP_LINES    = 3'd0;
  localparam logic [2:0] REG_LINE_LIMIT    = 3'd1;
  localparam logic [2:0] REG_EMPTY_FILL    = 3'd2;
  localparam logic [2:0] REG_SELECT_ENABLE = 3'd3;
  localparam logic [2:0] REG_COLUMN_MASK   = 3'd4;

  // field scan phases
  localparam logic [2:0] PH_EMPTY = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_INT   = 3'd2;
  localparam logic [2:0] PH_FRAC  = 3'd3;
  localparam logic [2:0] PH_ESIGN = 3'd4;
  localparam logic [2:0] PH_EXP   = 3'd5;

  // characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [39:0] INT_TOP = 40'hFF_FFFF_FFFF;
  localparam logic [8:0]  EXP_TOP = 9'd511;

  typedef struct packed {
    logic [31:0] skip_lines;
    logic [31:0] line_limit;
    logic [63:0] empty_fill;
    logic        select_enable;
    logic [63:0] column_mask;
  } csvp_cfg_t;

  // one result request from scanner to value unit
  typedef struct packed {
    logic        has;
    logic        empty;
    logic [39:0] int_acc;
    logic [29:0] frac_acc;
    logic [3:0]  frac_digits;
    logic [8:0]  exp_acc;
    logic        neg;
    logic        eneg;
    logic        ovf;
    logic [5:0]  col;
    logic [31:0] line;
    logic        eol;
    logic [31:0] done_cnt;
  } csvp_job_t;

  function automatic logic [29:0] pow10(input logic [3:0] n);
    logic [29:0] r;
    case (n)
      4'd0: r = 30'd1;
      4'd1: r = 30'd10;
      4'd2: r = 30'd100;
      4'd3: r = 30'd1000;
      4'd4: r = 30'd10000;
      4'd5: r = 30'd100000;
      4'd6: r = 30'd1000000;
      4'd7: r = 30'd10000000;
      4'd8: r = 30'd100000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/csvp_fifo.sv @@
module csvp_fifo import csvp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  csvp_job_t wdata,
  input  logic      pop,
  output csvp_job_t rdata,
  output logic      full,
  output logic      empty
);

  csvp_job_t  mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/csvp_front.sv @@
module csvp_front import csvp_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_FRACTION_DIGITS = 9
) (
  input  logic      clk,
  input  logic      rst,
  input  csvp_cfg_t cfg,
  input  logic      take,
  input  logic [7:0] text_byte,
  input  logic      end_of_data,
  output logic      push,
  output csvp_job_t job
);

  localparam logic [6:0] MAX_COL = 7'(MAX_COLUMNS);
  localparam logic [3:0] MAX_FD  = 4'(MAX_FRACTION_DIGITS);

  logic [2:0]  phase, phase_next;
  logic [31:0] line_count, line_count_next;
  logic [5:0]  column_count, column_count_next;
  logic        col_over, col_over_next;
  logic [39:0] int_acc, int_acc_next;
  logic [29:0] frac_acc, frac_acc_next;
  logic [3:0]  frac_digits, frac_digits_next;
  logic [8:0]  exp_acc, exp_acc_next;
  logic [2:0]  flags, flags_next;      // {ovf, eneg, neg}
  logic        prev_cr, prev_cr_next;
  logic [31:0] parsed, parsed_next;
  logic        produced;

  function automatic csvp_job_t make_job(
    input logic has, input logic [2:0] ph, input logic [39:0] ia, input logic [29:0] fa,
    input logic [3:0] fd, input logic [8:0] ea, input logic [2:0] fl,
    input logic [5:0] col, input logic [31:0] line, input logic eol,
    input logic [31:0] dn);
    csvp_job_t j;
    j.has = has;
    j.empty = (ph == PH_EMPTY);
    j.int_acc = ia;
    j.frac_acc = fa;
    j.frac_digits = fd;
    j.exp_acc = ea;
    j.neg = fl[0];
    j.eneg = fl[1];
    j.ovf = fl[2];
    j.col = has ? col : 6'd0;
    j.line = line;
    j.eol = eol;
    j.done_cnt = dn;
    return j;
  endfunction

  always_comb begin
    logic is_lf, is_cr, is_comma, skipping, lim_done, sel, sel2, open;
    logic [3:0]  d;
    logic [2:0]  ph;
    logic [43:0] it;
    logic [33:0] ft;
    logic [12:0] et;
    phase_next        = phase;
    line_count_next   = line_count;
    column_count_next = column_count;
    col_over_next     = col_over;
    int_acc_next      = int_acc;
    frac_acc_next     = frac_acc;
    frac_digits_next  = frac_digits;
    exp_acc_next      = exp_acc;
    flags_next        = flags;
    prev_cr_next      = prev_cr;
    parsed_next       = parsed;
    produced          = 1'b0;
    job               = '0;
    ph                = phase;
    open              = 1'b0;
    sel2              = 1'b0;
    is_lf    = (text_byte == CH_LF);
    is_cr    = (text_byte == CH_CR);
    is_comma = (text_byte == CH_COMMA);
    skipping = (line_count < cfg.skip_lines);
    lim_done = !skipping && (parsed >= cfg.line_limit);
    sel = !col_over && ({1'b0, column_count} < MAX_COL) &&
          (!cfg.select_enable || cfg.column_mask[column_count]);
    d  = 4'(text_byte - CH_0);
    it = ({4'b0, int_acc} << 3) + ({4'b0, int_acc} << 1) + 44'(d);
    ft = ({4'b0, frac_acc} << 3) + ({4'b0, frac_acc} << 1) + 34'(d);
    et = ({4'b0, exp_acc} << 3) + ({4'b0, exp_acc} << 1) + 13'(d);

    if (is_lf && prev_cr) begin
      prev_cr_next = 1'b0;
    end else begin
      prev_cr_next = is_cr;
      if (skipping) begin
        if (is_lf || is_cr) begin
          line_count_next = line_count + 32'd1;
          phase_next = PH_EMPTY;
          int_acc_next = '0; frac_acc_next = '0; frac_digits_next = '0;
          exp_acc_next = '0; flags_next = '0;
        end
      end else if (lim_done) begin
        // surplus text ignored
      end else if (is_lf || is_cr || (end_of_data && is_comma)) begin
        job = make_job(sel, phase, int_acc, frac_acc, frac_digits, exp_acc, flags,
                       column_count, line_count, 1'b1, parsed + 32'd1);
        produced = 1'b1;
        parsed_next = parsed + 32'd1;
        line_count_next = line_count + 32'd1;
        phase_next = PH_EMPTY;
        int_acc_next = '0; frac_acc_next = '0; frac_digits_next = '0;
        exp_acc_next = '0; flags_next = '0;
        column_count_next = '0;
        col_over_next = 1'b0;
      end else if (is_comma) begin
        if (sel) begin
          job = make_job(1'b1, phase, int_acc, frac_acc, frac_digits, exp_acc, flags,
                         column_count, line_count, 1'b0, parsed);
          produced = 1'b1;
        end
        if (!col_over) begin
          if (({1'b0, column_count} + 7'd1) >= MAX_COL) col_over_next = 1'b1;
          else column_count_next = column_count + 6'd1;
        end
        phase_next = PH_EMPTY;
        int_acc_next = '0; frac_acc_next = '0; frac_digits_next = '0;
        exp_acc_next = '0; flags_next = '0;
      end else begin
        ph = (phase == PH_EMPTY) ? PH_START : phase;
        if (text_byte >= CH_0 && text_byte <= CH_9) begin
          if (ph == PH_START || ph == PH_INT) begin
            ph = PH_INT;
            if (it > {4'b0, INT_TOP}) begin
              int_acc_next = INT_TOP;
              flags_next[2] = 1'b1;
            end else begin
              int_acc_next = it[39:0];
            end
          end else if (ph == PH_FRAC) begin
            if (frac_digits < MAX_FD && frac_digits < 4'd9) begin
              frac_acc_next = ft[29:0];
              frac_digits_next = frac_digits + 4'd1;
            end
          end else begin
            ph = PH_EXP;
            exp_acc_next = (et > {4'b0, EXP_TOP}) ? EXP_TOP : et[8:0];
          end
        end else if (text_byte == CH_MINUS) begin
          if (ph == PH_START) flags_next[0] = 1'b1;
          else if (ph == PH_ESIGN) begin
            flags_next[1] = 1'b1;
            ph = PH_EXP;
          end
        end else if (text_byte == CH_PLUS) begin
          if (ph == PH_ESIGN) ph = PH_EXP;
        end else if (text_byte == CH_DOT) begin
          if (ph == PH_START || ph == PH_INT) ph = PH_FRAC;
        end else if (text_byte == CH_E) begin
          if (ph == PH_START || ph == PH_INT || ph == PH_FRAC) ph = PH_ESIGN;
        end
        phase_next = ph;
      end
    end

    if (end_of_data) begin
      if (!produced) begin
        open = (phase_next != PH_EMPTY) || (column_count_next != 6'd0) || col_over_next;
        sel2 = !col_over_next && ({1'b0, column_count_next} < MAX_COL) &&
               (!cfg.select_enable || cfg.column_mask[column_count_next]);
        if (!skipping && !lim_done && open) begin
          job = make_job(sel2, phase_next, int_acc_next, frac_acc_next, frac_digits_next,
                         exp_acc_next, flags_next, column_count_next, line_count_next,
                         1'b1, parsed_next + 32'd1);
        end else begin
          job = make_job(1'b0, PH_EMPTY, '0, '0, '0, '0, '0, '0, line_count_next,
                         1'b0, parsed_next);
        end
        produced = 1'b1;
      end
      phase_next = PH_EMPTY;
      int_acc_next = '0; frac_acc_next = '0; frac_digits_next = '0;
      exp_acc_next = '0; flags_next = '0;
      line_count_next = '0;
      column_count_next = '0;
      col_over_next = 1'b0;
      prev_cr_next = 1'b0;
      parsed_next = '0;
    end
  end

  assign push = take && produced;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_EMPTY;
      line_count   <= '0;
      column_count <= '0;
      col_over     <= 1'b0;
      int_acc      <= '0;
      frac_acc     <= '0;
      frac_digits  <= '0;
      exp_acc      <= '0;
      flags        <= '0;
      prev_cr      <= 1'b0;
      parsed       <= '0;
    end else if (take) begin
      phase        <= phase_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
      col_over     <= col_over_next;
      int_acc      <= int_acc_next;
      frac_acc     <= frac_acc_next;
      frac_digits  <= frac_digits_next;
      exp_acc      <= exp_acc_next;
      flags        <= flags_next;
      prev_cr      <= prev_cr_next;
      parsed       <= parsed_next;
    end
  end

endmodule

@@ hdl/csvp_back.sv @@
module csvp_back import csvp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  csvp_cfg_t   cfg,
  input  logic        q_empty,
  input  csvp_job_t   q_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] number_value,
  output logic        has_value,
  output logic [5:0]  column_number,
  output logic [31:0] line_number,
  output logic        end_of_line,
  output logic        saturated,
  output logic [31:0] lines_done
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_EXP  = 2'd2;
  localparam logic [1:0] B_HOLD = 2'd3;

  logic [1:0]  state;
  csvp_job_t   job;
  logic [63:0] dq;
  logic [30:0] rem;
  logic [29:0] divisor;
  logic [6:0]  cnt;
  logic [71:0] v;
  logic [8:0]  k;
  logic [3:0]  sub;
  logic [3:0]  rem10;
  logic        ovf;
  logic [63:0] res_val;
  logic        res_sat;
  logic        load_out;

  // restoring divide, one quotient bit per cycle
  logic [31:0] rem_sh;
  logic        ge;
  logic [30:0] rem_step;
  logic [63:0] dq_step;
  assign rem_sh   = {rem, dq[63]};
  assign ge       = rem_sh >= {2'b0, divisor};
  assign rem_step = ge ? 31'(rem_sh - {2'b0, divisor}) : rem_sh[30:0];
  assign dq_step  = {dq[62:0], ge};

  // divide by ten, eight quotient bits per cycle, MSB first
  logic [7:0] q8;
  logic [3:0] r8;
  always_comb begin
    logic [4:0] t;
    r8 = (sub == 4'd0) ? 4'd0 : rem10;
    q8 = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r8, v[64 + i]};
      if (t >= 5'd10) begin
        q8[i] = 1'b1;
        r8 = 4'(t - 5'd10);
      end else begin
        r8 = t[3:0];
      end
    end
  end

  // saturate and sign
  logic        f_ovf;
  logic [63:0] fin_val;
  logic        fin_sat;
  always_comb begin
    f_ovf = ovf || (v[71:64] != 8'd0);
    if (!job.neg) begin
      fin_sat = f_ovf || v[63];
      fin_val = fin_sat ? 64'h7FFF_FFFF_FFFF_FFFF : v[63:0];
    end else begin
      fin_sat = f_ovf || (v[63:0] > 64'h8000_0000_0000_0000);
      fin_val = fin_sat ? 64'h8000_0000_0000_0000 : (64'd0 - v[63:0]);
    end
  end

  logic fin;
  always_comb begin
    if (!job.eneg)
      fin = (k == job.exp_acc) || ovf || (v[71:64] != 8'd0) || (v == 72'd0);
    else
      fin = (sub == 4'd0) && ((k == job.exp_acc) || (v == 72'd0));
  end

  assign pop      = (state == B_IDLE) && !q_empty;
  assign load_out = (state == B_HOLD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            job <= q_data;
            if (!q_data.has) begin
              res_val <= '0;
              res_sat <= 1'b0;
              state <= B_HOLD;
            end else if (q_data.empty) begin
              res_val <= cfg.empty_fill;
              res_sat <= 1'b0;
              state <= B_HOLD;
            end else begin
              dq <= {2'b0, q_data.frac_acc, 32'd0};
              rem <= '0;
              divisor <= pow10((q_data.frac_digits > 4'd9) ? 4'd9 : q_data.frac_digits);
              cnt <= 7'd64;
              ovf <= q_data.ovf;
              state <= B_DIV;
            end
          end
        end
        B_DIV: begin
          rem <= rem_step;
          dq <= dq_step;
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            v <= {job.int_acc, dq_step[31:0]};
            k <= '0;
            sub <= '0;
            state <= B_EXP;
          end
        end
        B_EXP: begin
          if (fin) begin
            res_val <= fin_val;
            res_sat <= fin_sat;
            state <= B_HOLD;
          end else if (!job.eneg) begin
            v <= (v << 3) + (v << 1);
            k <= k + 9'd1;
          end else begin
            v <= {v[63:0], q8};
            rem10 <= r8;
            if (sub == 4'd8) begin
              sub <= '0;
              k <= k + 9'd1;
            end else begin
              sub <= sub + 4'd1;
            end
          end
        end
        B_HOLD: begin
          if (load_out) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      number_value  <= res_val;
      has_value     <= job.has;
      column_number <= job.col;
      line_number   <= job.line;
      end_of_line   <= job.eol;
      saturated     <= res_sat;
      lines_done    <= job.done_cnt;
    end
  end

endmodule

@@ hdl/csv_numeric_field_parser_unit.sv @@
// Flow: an empty field or line marker passes the request queue, the value unit's hold
//   state and the output register; a number also passes the fraction divide and the
//   exponent steps. Scanning runs at one byte per cycle while the 2-entry request queue
//   has room; results drain at the value unit's rate.
// Reset: synchronous, active high; clears scan state, queue and output valid, and
//   loads the register reset values.
module csv_numeric_field_parser_unit import csvp_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_FRACTION_DIGITS = 9
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // text in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_data,
  // results out
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] number_value,
  output logic        has_value,
  output logic [5:0]  column_number,
  output logic [31:0] line_number,
  output logic        end_of_line,
  output logic        saturated,
  output logic [31:0] lines_done
);

  csvp_cfg_t cfg;
  csvp_job_t push_job;
  csvp_job_t q_data;
  logic      push, pop, q_full, q_empty, take;

  // Register writes are always taken; software must write only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_lines    <= 32'd0;
      cfg.line_limit    <= 32'hFFFF_FFFF;
      cfg.empty_fill    <= 64'd0;
      cfg.select_enable <= 1'b0;
      cfg.column_mask   <= 64'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SKIP_LINES:    cfg.skip_lines    <= cfg_data[31:0];
        REG_LINE_LIMIT:    cfg.line_limit    <= cfg_data[31:0];
        REG_EMPTY_FILL:    cfg.empty_fill    <= cfg_data;
        REG_SELECT_ENABLE: cfg.select_enable <= cfg_data[0];
        REG_COLUMN_MASK:   cfg.column_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Every byte yields at most one request, so a free queue slot is enough.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // Front: byte scanner, field accumulation, line and column bookkeeping.
  csvp_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
  ) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .take(take),
    .text_byte(text_byte), .end_of_data(end_of_data),
    .push(push), .job(push_job)
  );

  // Decouples the scanner from the multi-cycle value unit.
  csvp_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(push_job),
    .pop(pop), .rdata(q_data), .full(q_full), .empty(q_empty)
  );

  // Back: fraction divide, exponent scaling, saturation, output register.
  csvp_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_empty(q_empty), .q_data(q_data), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .number_value(number_value), .has_value(has_value),
    .column_number(column_number), .line_number(line_number),
    .end_of_line(end_of_line), .saturated(saturated), .lines_done(lines_done)
  );

endmodule

@@ hdl/csvp_checker.sv @@
`include "csv_numeric_field_parser_unit_defines.svh"

module csvp_props (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [63:0] number_value,
  input logic        has_value,
  input logic [5:0]  column_number,
  input logic        saturated
);

  `CSVP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(number_value), "result dropped or changed while stalled")
  `CSVP_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "output valid after reset")
  `CSVP_ASSERT(a_marker_zero, out_valid && !has_value |-> number_value == 64'sd0 && column_number == 6'd0 && !saturated, "marker carries data")
  `CSVP_ASSERT(a_sat_extreme, out_valid && saturated |-> number_value == 64'h7FFF_FFFF_FFFF_FFFF || number_value == 64'h8000_0000_0000_0000, "saturated value not at a limit")

endmodule

bind csv_numeric_field_parser_unit csvp_props u_csvp_checker (.*);

@@ tb/csvp_checker.sv @@
`timescale 1ns / 1ps

module csvp_checker import csvp_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_FRACTION_DIGITS = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] number_value,
  input  logic        has_value,
  input  logic [5:0]  column_number,
  input  logic [31:0] line_number,
  input  logic        end_of_line,
  input  logic        saturated,
  input  logic [31:0] lines_done,
  output int          fail_count,
  output int          outstanding,
  output int          results_seen,
  output int          saturations_seen
);

  localparam logic [63:0] M32 = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [63:0] value;
    logic        has;
    logic [5:0]  col;
    logic [31:0] line;
    logic        eol;
    logic        sat;
    logic [31:0] done_cnt;
  } field_result_t;

  field_result_t pending_fields[$];

  logic [31:0] skip_cfg, limit_cfg;
  logic [63:0] fill_cfg, mask_cfg;
  logic        sel_cfg;

  logic [2:0]  phase;
  logic [31:0] line_cnt, parsed_cnt;
  int          col_cnt;
  bit          col_over;
  logic [39:0] int_acc;
  logic [31:0] frac_acc;
  int          frac_n;
  int          exp_acc;
  bit          neg, eneg, ovf_flag, prev_cr;

  function automatic logic [63:0] ten_to(input int n);
    logic [63:0] r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  function void clear_field();
    phase = PH_EMPTY;
    int_acc = '0;
    frac_acc = '0;
    frac_n = 0;
    exp_acc = 0;
    neg = 0;
    eneg = 0;
    ovf_flag = 0;
  endfunction

  function void clear_stream();
    clear_field();
    line_cnt = '0;
    col_cnt = 0;
    col_over = 0;
    prev_cr = 0;
    parsed_cnt = '0;
  endfunction

  function bit col_selected();
    if (col_over || col_cnt >= MAX_COLUMNS) return 0;
    if (!sel_cfg) return 1;
    return mask_cfg[col_cnt];
  endfunction

  // Q32.32 value of the open field
  function void field_value(output logic [63:0] v, output logic sat);
    logic [63:0] hi, lo, mag, rem;
    bit ovf;
    int n;
    sat = 0;
    if (phase == PH_EMPTY) begin
      v = fill_cfg;
      return;
    end
    n = (frac_n > 9) ? 9 : frac_n;
    hi = {24'b0, int_acc};
    lo = ({34'b0, frac_acc[29:0]} << 32) / ten_to(n);
    ovf = ovf_flag;
    if (!eneg) begin
      for (int k = 0; k < exp_acc && !ovf && hi <= M32; k++) begin
        lo = lo * 10;
        hi = hi * 10 + (lo >> 32);
        lo = lo & M32;
      end
    end else begin
      for (int k = 0; k < exp_acc && (hi | lo) != 0; k++) begin
        rem = hi % 10;
        hi = hi / 10;
        lo = ((rem << 32) | lo) / 10;
      end
    end
    if (hi > M32) ovf = 1;
    mag = ovf ? 64'd0 : ((hi << 32) | lo);
    if (!neg) begin
      if (ovf || mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
        v = 64'h7FFF_FFFF_FFFF_FFFF;
        sat = 1;
      end else v = mag;
    end else begin
      if (ovf || mag > 64'h8000_0000_0000_0000) begin
        v = 64'h8000_0000_0000_0000;
        sat = 1;
      end else v = -mag;
    end
  endfunction

  function void add_expect(logic [63:0] v, logic has, logic [5:0] col, logic eol, logic sat,
                           logic [31:0] dn);
    field_result_t r;
    r.value = v;
    r.has = has;
    r.col = col;
    r.line = line_cnt;
    r.eol = eol;
    r.sat = sat;
    r.done_cnt = dn;
    pending_fields.insert(pending_fields.size(), r);
  endfunction

  function void feed_char(logic [7:0] c);
    logic [43:0] t;
    if (phase == PH_EMPTY) phase = PH_START;
    if (c >= CH_0 && c <= CH_9) begin
      if (phase == PH_START || phase == PH_INT) begin
        phase = PH_INT;
        t = {4'b0, int_acc} * 44'd10 + (c - CH_0);
        if (t > {4'b0, INT_TOP}) begin
          int_acc = INT_TOP;
          ovf_flag = 1;
        end else int_acc = t[39:0];
      end else if (phase == PH_FRAC) begin
        if (frac_n < MAX_FRACTION_DIGITS && frac_n < 9) begin
          frac_acc = frac_acc * 10 + (c - CH_0);
          frac_n++;
        end
      end else begin
        phase = PH_EXP;
        exp_acc = exp_acc * 10 + (c - CH_0);
        if (exp_acc > EXP_TOP) exp_acc = EXP_TOP;
      end
    end else if (c == CH_MINUS) begin
      if (phase == PH_START) neg = 1;
      else if (phase == PH_ESIGN) begin
        eneg = 1;
        phase = PH_EXP;
      end
    end else if (c == CH_PLUS) begin
      if (phase == PH_ESIGN) phase = PH_EXP;
    end else if (c == CH_DOT) begin
      if (phase == PH_START || phase == PH_INT) phase = PH_FRAC;
    end else if (c == CH_E) begin
      if (phase == PH_START || phase == PH_INT || phase == PH_FRAC) phase = PH_ESIGN;
    end
  endfunction

  function void close_line();
    logic [63:0] v;
    logic sat;
    if (col_selected()) begin
      field_value(v, sat);
      add_expect(v, 1, col_cnt[5:0], 1, sat, parsed_cnt + 1);
    end else add_expect('0, 0, '0, 1, 0, parsed_cnt + 1);
    parsed_cnt = parsed_cnt + 1;
    line_cnt = line_cnt + 1;
    clear_field();
    col_cnt = 0;
    col_over = 0;
  endfunction

  // one text byte through the scanner; returns 1 when it yields a result
  function bit scan_byte(logic [7:0] c, logic eod);
    bit is_lf, is_cr, skipping, surplus, made, open;
    logic [63:0] v;
    logic sat;
    is_lf = (c == CH_LF);
    is_cr = (c == CH_CR);
    skipping = line_cnt < skip_cfg;
    surplus = !skipping && parsed_cnt >= limit_cfg;
    made = 0;
    if (is_lf && prev_cr) prev_cr = 0;
    else begin
      prev_cr = is_cr;
      if (skipping) begin
        if (is_lf || is_cr) begin
          line_cnt = line_cnt + 1;
          clear_field();
        end
      end else if (surplus) begin
      end else if (is_lf || is_cr || (eod && c == CH_COMMA)) begin
        close_line();
        made = 1;
      end else if (c == CH_COMMA) begin
        if (col_selected()) begin
          field_value(v, sat);
          add_expect(v, 1, col_cnt[5:0], 0, sat, parsed_cnt);
          made = 1;
        end
        if (!col_over) begin
          if (col_cnt + 1 >= MAX_COLUMNS) col_over = 1;
          else col_cnt++;
        end
        clear_field();
      end else feed_char(c);
    end
    if (eod) begin
      if (!made) begin
        open = phase != PH_EMPTY || col_cnt != 0 || col_over;
        if (!skipping && !surplus && open) close_line();
        else add_expect('0, 0, '0, 0, 0, parsed_cnt);
        made = 1;
      end
      clear_stream();
    end
    return made;
  endfunction

  field_result_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      skip_cfg <= '0;
      limit_cfg <= '1;
      fill_cfg <= '0;
      sel_cfg <= 0;
      mask_cfg <= '0;
      clear_stream();
      pending_fields.delete();
      fail_count <= 0;
      outstanding <= 0;
      results_seen <= 0;
      saturations_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SKIP_LINES:    skip_cfg <= cfg_data[31:0];
          REG_LINE_LIMIT:    limit_cfg <= cfg_data[31:0];
          REG_EMPTY_FILL:    fill_cfg <= cfg_data;
          REG_SELECT_ENABLE: sel_cfg <= cfg_data[0];
          REG_COLUMN_MASK:   mask_cfg <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) void'(scan_byte(text_byte, end_of_data));
      if (out_valid && out_ready) begin
        got = '{number_value, has_value, column_number, line_number, end_of_line,
                saturated, lines_done};
        results_seen <= results_seen + 1;
        if (saturated) saturations_seen <= saturations_seen + 1;
        if (pending_fields.size() == 0) begin
          $display("%0t: unexpected result val=%h has=%b col=%0d line=%0d eol=%b sat=%b done=%0d",
                   $time, got.value, got.has, got.col, got.line, got.eol, got.sat,
                   got.done_cnt);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_fields.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected val=%h has=%b col=%0d line=%0d eol=%b sat=%b done=%0d",
                     $time, want.value, want.has, want.col, want.line, want.eol, want.sat,
                     want.done_cnt);
            $display("%0t:          actual   val=%h has=%b col=%0d line=%0d eol=%b sat=%b done=%0d",
                     $time, got.value, got.has, got.col, got.line, got.eol, got.sat,
                     got.done_cnt);
            fail_count <= fail_count + 1;
          end
        end
      end
      outstanding <= pending_fields.size();
    end
  end

endmodule

@@ tb/tb_csv_numeric_field_parser_unit.sv @@
`timescale 1ns / 1ps

module tb_csv_numeric_field_parser_unit;
  import csvp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 320;   // margin for the slowest number

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  text_byte = '0;
  logic        end_of_data = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic signed [63:0] number_value;
  logic        has_value;
  logic [5:0]  column_number;
  logic [31:0] line_number;
  logic        end_of_line;
  logic        saturated;
  logic [31:0] lines_done;

  int fail_count, outstanding, results_seen, saturations_seen;
  int bytes_sent, lines_sent, phases_run;
  int idle_cycles;
  bit no_gaps;         // burst stretch: sender never idles
  int out_stall;
  byte unsigned line_buf[$];

  always #2 clk = ~clk;

  csv_numeric_field_parser_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte),
    .end_of_data(end_of_data),
    .out_valid(out_valid), .out_ready(out_ready), .number_value(number_value),
    .has_value(has_value), .column_number(column_number), .line_number(line_number),
    .end_of_line(end_of_line), .saturated(saturated), .lines_done(lines_done)
  );

  csvp_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte),
    .end_of_data(end_of_data),
    .out_valid(out_valid), .out_ready(out_ready), .number_value(number_value),
    .has_value(has_value), .column_number(column_number), .line_number(line_number),
    .end_of_line(end_of_line), .saturated(saturated), .lines_done(lines_done),
    .fail_count(fail_count), .outstanding(outstanding), .results_seen(results_seen),
    .saturations_seen(saturations_seen)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side backpressure
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 0;
    end else if (no_gaps) out_ready <= 1;
    else begin
      out_stall <= pick_gap();
      out_ready <= 1;
    end
  end

  // watchdog: cycles with no accepted request on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results still expected", $time, outstanding);
        $display("[csv_numeric_field_parser_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic eod);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    text_byte <= b;
    end_of_data <= eod;
    @(posedge clk iff in_ready);
    bytes_sent++;
  endtask

  task automatic send_str(input string s, input bit eod_last);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], eod_last && i == s.len() - 1);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
  endtask

  task automatic set_regs(input logic [31:0] skip, input logic [31:0] limit,
                          input logic [63:0] fill, input logic sel, input logic [63:0] mask);
    write_reg(REG_SKIP_LINES, {32'b0, skip});
    write_reg(REG_LINE_LIMIT, {32'b0, limit});
    write_reg(REG_EMPTY_FILL, fill);
    write_reg(REG_SELECT_ENABLE, {63'b0, sel});
    write_reg(REG_COLUMN_MASK, mask);
    cfg_valid <= 0;
    phases_run++;
  endtask

  // block is idle: every expected result back, then let the last byte settle
  task automatic wait_drained();
    in_valid <= 0;
    end_of_data <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_byte(input byte unsigned b);
    line_buf.insert(line_buf.size(), b);
  endtask

  task automatic add_digits(input int n);
    for (int i = 0; i < n; i++) add_byte(8'(CH_0 + $urandom_range(0, 9)));
  endtask

  // one field: mostly well formed numbers, some empty, some garbage
  task automatic add_field();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return;   // empty field
    if (r < 15) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 2) == 0) add_byte(CH_MINUS);
    if ($urandom_range(0, 19) == 0) add_digits($urandom_range(11, 16));   // long integer, may overflow
    else add_digits($urandom_range(0, 6));
    if ($urandom_range(0, 1)) begin
      add_byte(CH_DOT);
      add_digits($urandom_range(0, 12));
    end
    if ($urandom_range(0, 3) == 0) begin
      add_byte(CH_E);
      case ($urandom_range(0, 2))
        0: add_byte(CH_MINUS);
        1: add_byte(CH_PLUS);
        default: ;
      endcase
      add_digits($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(0, 4));
    end
    if ($urandom_range(0, 9) == 0)
      line_buf.insert($urandom_range(0, line_buf.size()), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_line(input bit eod_last);
    int ncols;
    line_buf.delete();
    ncols = ($urandom_range(0, 39) == 0) ? $urandom_range(63, 70) : $urandom_range(1, 6);
    for (int c = 0; c < ncols; c++) begin
      add_field();
      if (c != ncols - 1) add_byte(CH_COMMA);
    end
    case ($urandom_range(0, 3))
      0: add_byte(CH_CR);
      1: begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end
      2: if (eod_last) add_byte(CH_COMMA);   // comma closes the line at end of data
         else add_byte(CH_LF);
      default: add_byte(CH_LF);
    endcase
    no_gaps = ($urandom_range(0, 4) == 0);
    foreach (line_buf[i]) put_byte(line_buf[i], eod_last && i == line_buf.size() - 1);
    lines_sent++;
  endtask

  task automatic run_text(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_line($urandom_range(0, 24) == 0);
    put_byte(CH_LF, 1);   // close the stream
    no_gaps = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, then edge values of every field
    set_regs(0, 32'hFFFF_FFFF, 64'h0, 0, 64'h0);
    send_str("0,1.5,-2.25,,3e2,7e-1\r\n", 0);
    send_str("1099511627775,9999999999999,-4294967296.5,0.123456789012,9e9,1e-511\n", 0);
    send_str("x-1.-5,e+,--,.,ee\r", 0);
    send_str("4294967295.999999999,-2147483648e1,,", 1);
    wait_drained();

    // extremes of the registers
    set_regs(2, 3, 64'h8000_0000_0000_0000, 1, 64'h8000_0000_0000_0005);
    run_text(150);
    wait_drained();
    set_regs(0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    run_text(60);
    wait_drained();
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h1, 1, 64'hFFFF_FFFF_FFFF_FFFF);
    run_text(60);
    wait_drained();
    set_regs(0, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1, 64'h0);
    run_text(80);
    wait_drained();

    // random settings, mostly all-parsing so numbers dominate
    for (int p = 0; p < 8; p++) begin
      set_regs($urandom_range(0, 2), $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : '1,
               {$urandom, $urandom}, $urandom_range(0, 2) == 0,
               {$urandom, $urandom} | 64'h3F);
      run_text(100);
      wait_drained();
    end

    $display("Covered %0d bytes in %0d lines over %0d register settings;", bytes_sent,
             lines_sent, phases_run);
    $display("checked %0d results, %0d of them saturated.", results_seen, saturations_seen);
    if (fail_count == 0) $display("[csv_numeric_field_parser_unit] OK");
    else $display("[csv_numeric_field_parser_unit] ERROR");
    $finish;
  end

endmodule

@@ csv_numeric_field_parser_unit.f @@
+incdir+hdl
hdl/csvp_pkg.sv
hdl/csvp_fifo.sv
hdl/csvp_front.sv
hdl/csvp_back.sv
hdl/csv_numeric_field_parser_unit.sv
hdl/csvp_checker.sv
tb/csvp_checker.sv
tb/tb_csv_numeric_field_parser_unit.sv
